// File: rtl/pgc_pkg.sv
package pgc_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned MID_GRAY   = 128;
    localparam int unsigned RAMP_DIV   = 127;
    localparam int unsigned FULL_SCALE = 255;

    // n/127 estimate: (n * 129) >> 14, never high, at most one low for n < 2^15
    localparam int unsigned RAMP_RECIP = 129;
    localparam int unsigned RAMP_SHIFT = 14;

    // gray weights, sum shifted right by GRAY_SHIFT
    localparam int unsigned GRAY_WR    = 11;
    localparam int unsigned GRAY_WG    = 16;
    localparam int unsigned GRAY_WB    = 5;
    localparam int unsigned GRAY_SHIFT = 5;

    typedef enum logic [1:0] {
        REG_TINT_RED      = 2'd0,
        REG_TINT_GREEN    = 2'd1,
        REG_TINT_BLUE     = 2'd2,
        REG_TINT_STRENGTH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] strength;
    } t_tint_cfg;

endpackage

// File: rtl/pgc_regs.sv
module pgc_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pgc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pgc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pgc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output pgc_pkg::t_tint_cfg                o_cfg
);

    pgc_pkg::t_tint_cfg r_cfg;
    pgc_pkg::t_tint_cfg n_cfg;
    pgc_pkg::t_reg_idx  reg_idx;
    logic               wr_en;
    logic [pgc_pkg::PIX_W-1:0] wdat;
    logic [pgc_pkg::PIX_W-1:0] rdat;

    assign reg_idx = pgc_pkg::t_reg_idx'(paddr[pgc_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign wdat    = pwdata[pgc_pkg::PIX_W-1:0];
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                pgc_pkg::REG_TINT_RED:      n_cfg.red      = wdat;
                pgc_pkg::REG_TINT_GREEN:    n_cfg.green    = wdat;
                pgc_pkg::REG_TINT_BLUE:     n_cfg.blue     = wdat;
                pgc_pkg::REG_TINT_STRENGTH: n_cfg.strength = wdat;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pgc_pkg::REG_TINT_RED:      rdat = r_cfg.red;
            pgc_pkg::REG_TINT_GREEN:    rdat = r_cfg.green;
            pgc_pkg::REG_TINT_BLUE:     rdat = r_cfg.blue;
            pgc_pkg::REG_TINT_STRENGTH: rdat = r_cfg.strength;
        endcase
    end

    assign prdata = {{(pgc_pkg::APB_DATA_W-pgc_pkg::PIX_W){1'b0}}, rdat};
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/pgc_gray.sv
module pgc_gray (
    input  logic                      i_clk,
    input  logic [pgc_pkg::PIX_W-1:0] i_red,
    input  logic [pgc_pkg::PIX_W-1:0] i_green,
    input  logic [pgc_pkg::PIX_W-1:0] i_blue,
    input  logic [pgc_pkg::PIX_W-1:0] i_alpha,
    output logic [pgc_pkg::PIX_W-1:0] o_gray,
    output logic [pgc_pkg::PIX_W-1:0] o_red,
    output logic [pgc_pkg::PIX_W-1:0] o_green,
    output logic [pgc_pkg::PIX_W-1:0] o_blue,
    output logic [pgc_pkg::PIX_W-1:0] o_alpha
);

    localparam int unsigned SUM_W = pgc_pkg::PIX_W + pgc_pkg::GRAY_SHIFT;

    logic [SUM_W-1:0]          wsum;
    logic [pgc_pkg::PIX_W-1:0] n_gray;
    logic [pgc_pkg::PIX_W-1:0] r_gray;
    logic [pgc_pkg::PIX_W-1:0] r_red;
    logic [pgc_pkg::PIX_W-1:0] r_green;
    logic [pgc_pkg::PIX_W-1:0] r_blue;
    logic [pgc_pkg::PIX_W-1:0] r_alpha;

    // weights add up to 32, so the shifted sum stays within 8 bits
    always_comb begin
        wsum = SUM_W'(pgc_pkg::GRAY_WR) * SUM_W'(i_red)
             + SUM_W'(pgc_pkg::GRAY_WG) * SUM_W'(i_green)
             + SUM_W'(pgc_pkg::GRAY_WB) * SUM_W'(i_blue);
        n_gray = wsum[SUM_W-1:pgc_pkg::GRAY_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        r_gray  <= n_gray;
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
        r_alpha <= i_alpha;
    end

    assign o_gray  = r_gray;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

endmodule

// File: rtl/pgc_ramp.sv
module pgc_ramp (
    input  logic                      i_clk,
    input  logic [pgc_pkg::PIX_W-1:0] i_gray,
    input  logic [pgc_pkg::PIX_W-1:0] i_tint,
    input  logic [pgc_pkg::PIX_W-1:0] i_src,
    output logic [pgc_pkg::PIX_W-1:0] o_ramp,
    output logic [pgc_pkg::PIX_W-1:0] o_src
);

    localparam int unsigned NUM_W = 15;
    localparam int unsigned PRD_W = 2 * pgc_pkg::PIX_W;
    localparam int unsigned EST_W = NUM_W + 7;

    // stage A: ramp numerator
    logic [pgc_pkg::PIX_W-1:0] op_a;
    logic [pgc_pkg::PIX_W-1:0] op_b;
    logic [NUM_W-1:0]          offs;
    logic [PRD_W-1:0]          prod;
    logic [PRD_W-1:0]          n_num;
    logic [NUM_W-1:0]          r_num_a;
    logic [pgc_pkg::PIX_W-1:0] r_src_a;

    // stage B: quotient estimate
    logic [EST_W-1:0]          scaled;
    logic [NUM_W-1:0]          r_num_b;
    logic [pgc_pkg::PIX_W-1:0] r_est_b;
    logic [pgc_pkg::PIX_W-1:0] r_src_b;

    // stage C: correction
    logic [NUM_W-1:0]          rem;
    logic [pgc_pkg::PIX_W-1:0] n_ramp;
    logic [pgc_pkg::PIX_W-1:0] r_ramp;
    logic [pgc_pkg::PIX_W-1:0] r_src_c;

    // upper half: (gray-128)*(255-tint) + 127*tint, lower half: gray*tint
    always_comb begin
        if (i_gray[pgc_pkg::PIX_W-1]) begin
            op_a = {1'b0, i_gray[pgc_pkg::PIX_W-2:0]};
            op_b = ~i_tint;
            offs = NUM_W'(pgc_pkg::RAMP_DIV) * NUM_W'(i_tint);
        end else begin
            op_a = i_gray;
            op_b = i_tint;
            offs = '0;
        end
        prod  = PRD_W'(op_a) * PRD_W'(op_b);
        n_num = prod + PRD_W'(offs);
    end

    assign scaled = EST_W'(r_num_a) * EST_W'(pgc_pkg::RAMP_RECIP);

    always_comb begin
        rem = r_num_b - NUM_W'(pgc_pkg::RAMP_DIV) * NUM_W'(r_est_b);
        if (rem >= NUM_W'(pgc_pkg::RAMP_DIV)) begin
            n_ramp = r_est_b + pgc_pkg::PIX_W'(1);
        end else begin
            n_ramp = r_est_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_a <= n_num[NUM_W-1:0];
        r_src_a <= i_src;
        r_num_b <= r_num_a;
        r_est_b <= scaled[pgc_pkg::RAMP_SHIFT +: pgc_pkg::PIX_W];
        r_src_b <= r_src_a;
        r_ramp  <= n_ramp;
        r_src_c <= r_src_b;
    end

    assign o_ramp = r_ramp;
    assign o_src  = r_src_c;

endmodule

// File: rtl/pgc_mix.sv
module pgc_mix (
    input  logic                      i_clk,
    input  logic [pgc_pkg::PIX_W-1:0] i_ramp,
    input  logic [pgc_pkg::PIX_W-1:0] i_src,
    input  logic [pgc_pkg::PIX_W-1:0] i_strength,
    output logic [pgc_pkg::PIX_W-1:0] o_pix
);

    localparam int unsigned M_W = 2 * pgc_pkg::PIX_W;

    logic [M_W-1:0]            n_mix;
    logic [M_W-1:0]            r_mix_a;
    logic [M_W-1:0]            est_sum;
    logic [M_W-1:0]            r_mix_b;
    logic [pgc_pkg::PIX_W-1:0] r_est_b;
    logic [M_W-1:0]            rem;
    logic [pgc_pkg::PIX_W-1:0] n_pix;
    logic [pgc_pkg::PIX_W-1:0] r_pix;

    // A*t + (255-A)*S, at most 255*255
    assign n_mix = M_W'(i_strength) * M_W'(i_ramp)
                 + M_W'(pgc_pkg::FULL_SCALE - i_strength) * M_W'(i_src);

    // m/255 estimate: (m + m/256) / 256, never high, at most one low
    assign est_sum = r_mix_a + (r_mix_a >> pgc_pkg::PIX_W);

    always_comb begin
        rem = r_mix_b - M_W'(pgc_pkg::FULL_SCALE) * M_W'(r_est_b);
        if (rem >= M_W'(pgc_pkg::FULL_SCALE)) begin
            n_pix = r_est_b + pgc_pkg::PIX_W'(1);
        end else begin
            n_pix = r_est_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mix_a <= n_mix;
        r_mix_b <= r_mix_a;
        r_est_b <= est_sum[M_W-1:pgc_pkg::PIX_W];
        r_pix   <= n_pix;
    end

    assign o_pix = r_pix;

endmodule

// File: rtl/pixel_gray_colorize_tint.sv
// Gray colorize with tint blend, one RGBA pixel per transfer.
//
// Input channel: drive i_src_* and raise start; the pixel is taken at any
// clock edge with start high and busy low. busy is tied low, so a new pixel
// can be taken every cycle.
// Output channel: o_valid is high for exactly one cycle per pixel, with the
// colorized channels and the unchanged source alpha on o_out_*. The receiver
// must take the result in that cycle; there is no back-pressure.
// Pipeline: an accepted pixel passes through the registered stages gray,
// ramp numerator, /127 estimate, /127 fix, blend, /255 estimate and /255
// fix, and o_valid rises with the last of them. Throughput: one pixel per
// clock, set by the fully registered seven-stage datapath.
// Configuration: APB registers at byte address 0 (tint red), 4 (tint green),
// 8 (tint blue) and 12 (tint strength), 8 bits each, read back on prdata.
// Write them only while no pixel is in flight.
// Reset (i_rst_n low, synchronous): registers go to zero and in-flight
// pixels are dropped.
module pixel_gray_colorize_tint (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pgc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pgc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pgc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [pgc_pkg::PIX_W-1:0]         i_src_red,
    input  logic [pgc_pkg::PIX_W-1:0]         i_src_green,
    input  logic [pgc_pkg::PIX_W-1:0]         i_src_blue,
    input  logic [pgc_pkg::PIX_W-1:0]         i_src_alpha,
    output logic                              o_valid,
    output logic [pgc_pkg::PIX_W-1:0]         o_out_red,
    output logic [pgc_pkg::PIX_W-1:0]         o_out_green,
    output logic [pgc_pkg::PIX_W-1:0]         o_out_blue,
    output logic [pgc_pkg::PIX_W-1:0]         o_out_alpha
);

    localparam int unsigned DEPTH     = 7;
    localparam int unsigned ALPHA_DLY = DEPTH - 1;

    pgc_pkg::t_tint_cfg        cfg;
    logic                      in_xfer;
    logic [DEPTH-1:0]          r_vld;
    logic [DEPTH-1:0]          n_vld;

    logic [pgc_pkg::PIX_W-1:0] s1_gray;
    logic [pgc_pkg::PIX_W-1:0] s1_red;
    logic [pgc_pkg::PIX_W-1:0] s1_green;
    logic [pgc_pkg::PIX_W-1:0] s1_blue;
    logic [pgc_pkg::PIX_W-1:0] s1_alpha;

    logic [pgc_pkg::PIX_W-1:0] rp_red;
    logic [pgc_pkg::PIX_W-1:0] rp_green;
    logic [pgc_pkg::PIX_W-1:0] rp_blue;
    logic [pgc_pkg::PIX_W-1:0] src_red_d;
    logic [pgc_pkg::PIX_W-1:0] src_green_d;
    logic [pgc_pkg::PIX_W-1:0] src_blue_d;

    logic [pgc_pkg::PIX_W-1:0] r_alpha_dly [ALPHA_DLY];

    pgc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy    = 1'b0;
    assign in_xfer = start & ~busy;

    pgc_gray u_gray (
        .i_clk   (i_clk),
        .i_red   (i_src_red),
        .i_green (i_src_green),
        .i_blue  (i_src_blue),
        .i_alpha (i_src_alpha),
        .o_gray  (s1_gray),
        .o_red   (s1_red),
        .o_green (s1_green),
        .o_blue  (s1_blue),
        .o_alpha (s1_alpha)
    );

    pgc_ramp u_ramp_red (
        .i_clk  (i_clk),
        .i_gray (s1_gray),
        .i_tint (cfg.red),
        .i_src  (s1_red),
        .o_ramp (rp_red),
        .o_src  (src_red_d)
    );

    pgc_ramp u_ramp_green (
        .i_clk  (i_clk),
        .i_gray (s1_gray),
        .i_tint (cfg.green),
        .i_src  (s1_green),
        .o_ramp (rp_green),
        .o_src  (src_green_d)
    );

    pgc_ramp u_ramp_blue (
        .i_clk  (i_clk),
        .i_gray (s1_gray),
        .i_tint (cfg.blue),
        .i_src  (s1_blue),
        .o_ramp (rp_blue),
        .o_src  (src_blue_d)
    );

    pgc_mix u_mix_red (
        .i_clk      (i_clk),
        .i_ramp     (rp_red),
        .i_src      (src_red_d),
        .i_strength (cfg.strength),
        .o_pix      (o_out_red)
    );

    pgc_mix u_mix_green (
        .i_clk      (i_clk),
        .i_ramp     (rp_green),
        .i_src      (src_green_d),
        .i_strength (cfg.strength),
        .o_pix      (o_out_green)
    );

    pgc_mix u_mix_blue (
        .i_clk      (i_clk),
        .i_ramp     (rp_blue),
        .i_src      (src_blue_d),
        .i_strength (cfg.strength),
        .o_pix      (o_out_blue)
    );

    assign n_vld = {r_vld[DEPTH-2:0], in_xfer};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // alpha rides alongside the color stages
    always_ff @(posedge i_clk) begin
        r_alpha_dly[0] <= s1_alpha;
        for (int i = 1; i < ALPHA_DLY; i++) begin
            r_alpha_dly[i] <= r_alpha_dly[i-1];
        end
    end

    assign o_valid     = r_vld[DEPTH-1];
    assign o_out_alpha = r_alpha_dly[ALPHA_DLY-1];

endmodule
